// ----- src/gwv_pkg.sv -----
// ----------------------------------------------------------------------------
// Grouped Welford variance package
// Shared types, command codes and sizes for the grouped variance block.
// ----------------------------------------------------------------------------
package gwv_pkg;

  localparam int GROUP_COUNT = 256;
  localparam int GROUP_W     = 8;

  localparam logic [1:0]  CMD_ACC   = 2'd0;
  localparam logic [1:0]  CMD_CLR   = 2'd1;
  localparam logic [1:0]  CMD_READ  = 2'd2;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
  localparam logic [63:0] M2_MAX    = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [GROUP_W-1:0] group_index;
    logic signed [31:0] sample_value;
    logic               sample_null;
  } in_item_t;

  typedef struct packed {
    logic               result_empty;
    logic [31:0]        result_count;
    logic signed [31:0] result_mean;
    logic [63:0]        result_m2;
  } out_item_t;

  typedef struct packed {
    logic [31:0] count;
    logic [31:0] mean;
    logic [63:0] m2;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic prep;
    logic div_start;
    logic fin;
    logic d2;
    logic mul;
    logic wr;
    logic clr;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       acc_go;
    logic       div_busy;
    logic       out_free;
  } ctrl_status_t;

endpackage

// ----- src/grouped_welford_variance_top.sv -----
// An accumulate request occupies the block through capture, lookup, divider start,
// the divide state, finish, second difference, multiply and write-back; most of it
// is the one-bit-per-cycle divider. Clear, null-sample and unused requests go from
// lookup back to idle. A read does so when the result register is free and waits
// in lookup while it is not; its result is registered from the lookup state.
// Reset (rst, synchronous) empties every group at once and clears the partial flag.
// ----------------------------------------------------------------------------
// Grouped Welford variance top level
// Per-group running count, mean and m2 with read, clear and accumulate.
// ----------------------------------------------------------------------------
module grouped_welford_variance_top import gwv_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  ctrl_cmd_t    ctl;
  ctrl_status_t status;

  assign cfg_ready = 1'b1;

  gwv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .ctl      (ctl)
  );

  gwv_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    ctl.div_start |-> !status.div_busy)
    else $error("divider started while busy");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> status.out_free)
    else $error("pending result overwritten");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !(ctl.wr || ctl.div_start || ctl.out_load || ctl.clr))
    else $error("datapath request while accepting");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    ctl.capture |=> !in_ready)
    else $error("second request accepted during lookup");

endmodule

// ----- src/gwv_div.sv -----
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division of two 32-bit values, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gwv_div import gwv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [31:0] quotient
);

  logic [4:0]  cnt;
  logic [32:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic [32:0] rem_sh;
  logic [32:0] diff;

  assign rem_sh   = {rem[31:0], quo[31]};
  assign diff     = rem_sh - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 5'd1;
      if (cnt == 5'd31) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (!diff[32]) begin
        rem <= diff;
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

endmodule

// ----- src/gwv_ctrl.sv -----
// ----------------------------------------------------------------------------
// Grouped Welford variance controller
// Sequences lookup, division, update, clear and result requests over the datapath.
// ----------------------------------------------------------------------------
module gwv_ctrl import gwv_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  ctrl_status_t status,
  output ctrl_cmd_t    ctl
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOOK   = 3'd1;
  localparam logic [2:0] S_DSTART = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;
  localparam logic [2:0] S_D2     = 3'd5;
  localparam logic [2:0] S_MUL    = 3'd6;
  localparam logic [2:0] S_WR     = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_next  = S_LOOK;
        end
      end
      S_LOOK: begin
        unique case (status.cmd)
          CMD_ACC: begin
            if (status.acc_go) begin
              ctl.prep   = 1'b1;
              state_next = S_DSTART;
            end else begin
              state_next = S_IDLE;
            end
          end
          CMD_CLR: begin
            ctl.clr    = 1'b1;
            state_next = S_IDLE;
          end
          CMD_READ: begin
            if (status.out_free) begin
              ctl.out_load = 1'b1;
              state_next   = S_IDLE;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_DSTART: begin
        ctl.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (!status.div_busy) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        ctl.fin    = 1'b1;
        state_next = S_D2;
      end
      S_D2: begin
        ctl.d2     = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        ctl.mul    = 1'b1;
        state_next = S_WR;
      end
      S_WR: begin
        ctl.wr     = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- src/gwv_dp.sv -----
// ----------------------------------------------------------------------------
// Grouped Welford variance datapath
// Group table, update arithmetic, divider and the result register.
// ----------------------------------------------------------------------------
module gwv_dp import gwv_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  in_item_t     in_data,
  input  logic         cfg_valid,
  input  logic         cfg_data,
  input  ctrl_cmd_t    ctl,
  output ctrl_status_t status,
  output logic         out_valid,
  input  logic         out_ready,
  output out_item_t    out_data
);

  entry_t                 mem [GROUP_COUNT];
  logic [GROUP_COUNT-1:0] vld;
  logic                   partial;

  in_item_t    item;
  entry_t      rd;
  logic        rd_vld;
  logic [31:0] cnt_e;
  logic [31:0] mean_e;
  logic [63:0] m2_e;
  logic        grp_ok;

  logic [32:0] d1;
  logic [31:0] n_new;
  logic [32:0] d1_q;
  logic [31:0] n_q;
  logic [31:0] d1abs;
  logic [31:0] d1abs_q;
  logic        div_busy;
  logic [31:0] quo;
  logic [32:0] qs;
  logic [32:0] newm33;
  logic [31:0] newm_q;
  logic [32:0] d2;
  logic [31:0] d2abs_q;
  logic [63:0] prod_q;
  logic [64:0] m2_sum;
  logic [63:0] m2_new;

  assign grp_ok = 32'(item.group_index) < 32'(GROUP_COUNT);

  // An entry that was cleared, or never written since reset, reads as zero.
  assign cnt_e  = rd_vld ? rd.count : '0;
  assign mean_e = rd_vld ? rd.mean  : '0;
  assign m2_e   = rd_vld ? rd.m2    : '0;

  assign status.cmd      = item.cmd;
  assign status.acc_go   = grp_ok & ~item.sample_null;
  assign status.div_busy = div_busy;
  assign status.out_free = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      item <= in_data;
      rd   <= mem[in_data.group_index];
    end
    if (ctl.wr && grp_ok) begin
      mem[item.group_index] <= '{count: n_q, mean: newm_q, m2: m2_new};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      rd_vld  <= 1'b0;
      partial <= 1'b0;
    end else begin
      if (cfg_valid) begin
        partial <= cfg_data;
      end
      if (ctl.capture) begin
        rd_vld <= vld[in_data.group_index];
      end
      if (ctl.wr && grp_ok) begin
        vld[item.group_index] <= 1'b1;
      end else if (ctl.clr && grp_ok) begin
        vld[item.group_index] <= 1'b0;
      end
    end
  end

  assign d1    = {item.sample_value[31], item.sample_value} - {mean_e[31], mean_e};
  assign n_new = (cnt_e == COUNT_MAX) ? cnt_e : cnt_e + 32'd1;
  assign d1abs = d1_q[32] ? 32'(-d1_q) : d1_q[31:0];

  gwv_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (d1abs),
    .divisor  (n_q),
    .busy     (div_busy),
    .quotient (quo)
  );

  // The quotient takes the sign of d1, which truncates toward zero.
  assign qs     = d1_q[32] ? -{1'b0, quo} : {1'b0, quo};
  assign newm33 = {mean_e[31], mean_e} + qs;
  assign d2     = {item.sample_value[31], item.sample_value} - {newm_q[31], newm_q};
  assign m2_sum = {1'b0, m2_e} + {1'b0, prod_q};
  assign m2_new = m2_sum[64] ? M2_MAX : m2_sum[63:0];

  always_ff @(posedge clk) begin
    if (ctl.prep) begin
      d1_q <= d1;
      n_q  <= n_new;
    end
    if (ctl.div_start) begin
      d1abs_q <= d1abs;
    end
    if (ctl.fin) begin
      newm_q <= newm33[31:0];
    end
    if (ctl.d2) begin
      d2abs_q <= d2[32] ? 32'(-d2) : d2[31:0];
    end
    if (ctl.mul) begin
      prod_q <= 64'(d1abs_q) * 64'(d2abs_q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_data <= '0;
      if (grp_ok && cnt_e != '0) begin
        out_data.result_m2 <= m2_e;
        if (partial) begin
          out_data.result_count <= cnt_e;
          out_data.result_mean  <= mean_e;
        end
      end else begin
        out_data.result_empty <= 1'b1;
      end
    end
  end

endmodule
